[hw/rtl/spsd_pkg.sv]
// Shared types and constants for the steering and pedal smoother with delay.
// Used by spsd_core, spsd_ring, the top level and the checker; no dependencies.
package spsd_pkg;

	// Ring depth; pointer arithmetic wraps by truncation, so keep it a power of two.
	localparam int DelayDepth = 32;
	localparam int PtrW = $clog2(DelayDepth);

	localparam int PosLimit = 1048576;
	localparam int VelMax = 8388607;
	localparam int VelMin = -8388608;
	localparam int NoiseLimit = 1966;
	localparam int SteerLimit = 16384;

	localparam logic [15:0] SpringGainRst = 16'd15729;
	localparam logic [15:0] DampingGainRst = 16'd3518;
	localparam logic [15:0] TimeStepRst = 16'd197;
	localparam logic [15:0] NoiseDecayRst = 16'd983;
	localparam logic [15:0] NoiseGainRst = 16'd0;
	localparam logic [15:0] ThrottleStepRst = 16'd786;
	localparam logic [15:0] BrakeStepRst = 16'd983;
	localparam logic [4:0] DelaySamplesRst = 5'd8;

	typedef enum logic [3:0] {
		RegSpringGain = 4'd0,
		RegDampingGain = 4'd1,
		RegTimeStep = 4'd2,
		RegNoiseDecay = 4'd3,
		RegNoiseGain = 4'd4,
		RegThrottleStep = 4'd5,
		RegBrakeStep = 4'd6,
		RegDelaySamples = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] spring_gain;
		logic [15:0] damping_gain;
		logic [15:0] time_step;
		logic [15:0] noise_decay;
		logic [15:0] noise_gain;
		logic [15:0] throttle_step;
		logic [15:0] brake_step;
		logic [4:0] delay_samples;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] steer;
		logic [14:0] throttle;
		logic [14:0] brake;
	} ring_entry_t;

	// Core to ring: one write of the new sample and the delayed read, same cycle.
	typedef struct packed {
		logic en;
		logic [PtrW-1:0] lag;
		ring_entry_t wdata;
	} ring_req_t;

	typedef struct packed {
		logic idle;
		logic res_rdy;
	} core_stat_t;

endpackage

[hw/rtl/spsd_ring.sv]
// Delay ring: synchronous memory of result entries with per-entry valid bits.
// Depends on spsd_pkg (entry and request types, depth).
module spsd_ring (
	input logic clk,
	input logic arst_n,
	input spsd_pkg::ring_req_t req,
	output spsd_pkg::ring_entry_t rdata
);

	spsd_pkg::ring_entry_t mem [spsd_pkg::DelayDepth];
	logic [spsd_pkg::DelayDepth-1:0] valid_q;
	logic [spsd_pkg::PtrW-1:0] wp_q;
	logic [spsd_pkg::PtrW-1:0] rd_addr;

	spsd_pkg::ring_entry_t mem_rd_s1;
	spsd_pkg::ring_entry_t wdat_s1;
	logic hit_s1;
	logic vld_s1;

	// newest entry sits at wp_q; lag of one reads it back
	assign rd_addr = wp_q + spsd_pkg::PtrW'(1) - req.lag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			valid_q <= '0;
		end else if (req.en) begin
			wp_q <= wp_q + spsd_pkg::PtrW'(1);
			valid_q[wp_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.en) begin
			mem[wp_q] <= req.wdata;
			mem_rd_s1 <= mem[rd_addr];
			wdat_s1 <= req.wdata;
			hit_s1 <= (rd_addr == wp_q);
			vld_s1 <= valid_q[rd_addr];
		end
	end

	// forward the entry being written; never-written entries read as zero
	always_comb begin
		if (hit_s1) begin
			rdata = wdat_s1;
		end else if (vld_s1) begin
			rdata = mem_rd_s1;
		end else begin
			rdata = '0;
		end
	end

endmodule

[hw/rtl/spsd_core.sv]
// Sample sequencer: spring-damper column and noise offset on one shared 17x24
// multiplier, plus pedal slew. Depends on spsd_pkg; drives the spsd_ring request.
module spsd_core (
	input logic clk,
	input logic arst_n,
	input spsd_pkg::cfg_t cfg,
	input logic start,
	input logic signed [15:0] target_steer,
	input logic [14:0] throttle_in,
	input logic [14:0] brake_in,
	input logic signed [15:0] noise_sample,
	input logic take,
	output spsd_pkg::core_stat_t stat,
	output spsd_pkg::ring_req_t ring_req
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_ERR,
		ST_MUL_DAMP,
		ST_VEL,
		ST_DECAY,
		ST_POS,
		ST_NOISE,
		ST_STORE,
		ST_RESULT
	} state_t;

	state_t state_q;

	// sample latched at accept
	logic signed [15:0] tgt_q;
	logic [14:0] thr_req_q;
	logic [14:0] brk_req_q;
	logic signed [15:0] noise_q;

	// filter state
	logic signed [21:0] pos_q;
	logic signed [23:0] vel_q;
	logic signed [11:0] off_q;
	logic [14:0] thr_lvl_q;
	logic [14:0] brk_lvl_q;

	// working registers
	logic signed [16:0] mul_a;
	logic signed [23:0] mul_b;
	logic signed [40:0] prod_s1;
	logic signed [40:0] acc_q;
	logic signed [12:0] off_tmp_q;

	logic signed [22:0] err;
	logic signed [41:0] diff;
	logic signed [41:0] dv_full;
	logic signed [25:0] dv;
	logic signed [26:0] vsum;
	logic signed [23:0] vel_nx;
	logic signed [40:0] r16_full;
	logic signed [12:0] rdec;
	logic signed [12:0] off_tmp_nx;
	logic signed [24:0] rpos;
	logic signed [25:0] psum;
	logic signed [21:0] pos_nx;
	logic signed [40:0] r21_full;
	logic signed [12:0] rn;
	logic signed [13:0] osum;
	logic signed [11:0] off_nx;
	logic signed [22:0] ssum;
	logic signed [22:0] rs_full;
	logic signed [16:0] rs;
	logic signed [15:0] steer_nx;
	logic [14:0] thr_nx;
	logic [14:0] brk_nx;

	function automatic logic [14:0] pedal_move(input logic [14:0] lvl, input logic [14:0] req,
			input logic [15:0] step);
		logic [14:0] lim;
		logic signed [15:0] slim;
		logic signed [15:0] d;
		lim = 15'((17'(step) + 17'd2) >> 2);
		slim = $signed({1'b0, lim});
		d = $signed({1'b0, req}) - $signed({1'b0, lvl});
		if (d > slim) begin
			d = slim;
		end else if (d < -slim) begin
			d = -slim;
		end
		pedal_move = lvl + d[14:0];
	endfunction

	// multiplier operand select; the product is registered in prod_s1
	always_comb begin
		mul_a = $signed({1'b0, cfg.spring_gain});
		mul_b = 24'(err);
		case (state_q)
			ST_MUL_DAMP: begin
				mul_a = $signed({1'b0, cfg.damping_gain});
				mul_b = vel_q;
			end
			ST_VEL: begin
				mul_a = $signed({1'b0, cfg.noise_decay});
				mul_b = 24'(off_q);
			end
			ST_DECAY: begin
				mul_a = $signed({1'b0, cfg.time_step});
				mul_b = vel_q;
			end
			ST_POS: begin
				mul_a = $signed({1'b0, cfg.noise_gain});
				mul_b = 24'(noise_q);
			end
			default: begin
				mul_a = $signed({1'b0, cfg.spring_gain});
				mul_b = 24'(err);
			end
		endcase
	end

	always_comb begin
		err = 23'($signed({tgt_q, 6'b0})) - 23'(pos_q);

		// velocity: acc holds spring*err, prod holds damping*vel
		diff = 42'(acc_q) - 42'(prod_s1);
		dv_full = (diff + 42'sd32768) >>> 16;
		dv = dv_full[25:0];
		vsum = 27'(vel_q) + 27'(dv);
		if (vsum > 27'(spsd_pkg::VelMax)) begin
			vel_nx = 24'(spsd_pkg::VelMax);
		end else if (vsum < 27'(spsd_pkg::VelMin)) begin
			vel_nx = 24'(spsd_pkg::VelMin);
		end else begin
			vel_nx = vsum[23:0];
		end

		// Q0.16 products share the same rounding
		r16_full = (prod_s1 + 41'sd32768) >>> 16;
		rdec = r16_full[12:0];
		off_tmp_nx = 13'(off_q) - rdec;
		rpos = r16_full[24:0];
		psum = 26'(pos_q) + 26'(rpos);
		if (psum > 26'(spsd_pkg::PosLimit)) begin
			pos_nx = 22'(spsd_pkg::PosLimit);
		end else if (psum < -26'(spsd_pkg::PosLimit)) begin
			pos_nx = -22'(spsd_pkg::PosLimit);
		end else begin
			pos_nx = psum[21:0];
		end

		r21_full = (prod_s1 + 41'sd1048576) >>> 21;
		rn = r21_full[12:0];
		osum = 14'(off_tmp_q) + 14'(rn);
		if (osum > 14'(spsd_pkg::NoiseLimit)) begin
			off_nx = 12'(spsd_pkg::NoiseLimit);
		end else if (osum < -14'(spsd_pkg::NoiseLimit)) begin
			off_nx = -12'(spsd_pkg::NoiseLimit);
		end else begin
			off_nx = osum[11:0];
		end

		// offset is Q0.15, position Q1.20: align by 2^5, then drop 6 bits
		ssum = 23'(pos_q) + 23'($signed({off_q, 5'b0}));
		rs_full = (ssum + 23'sd32) >>> 6;
		rs = rs_full[16:0];
		if (rs > 17'(spsd_pkg::SteerLimit)) begin
			steer_nx = 16'(spsd_pkg::SteerLimit);
		end else if (rs < -17'(spsd_pkg::SteerLimit)) begin
			steer_nx = -16'(spsd_pkg::SteerLimit);
		end else begin
			steer_nx = rs[15:0];
		end

		thr_nx = pedal_move(thr_lvl_q, thr_req_q, cfg.throttle_step);
		brk_nx = pedal_move(brk_lvl_q, brk_req_q, cfg.brake_step);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			vel_q <= '0;
			off_q <= '0;
			thr_lvl_q <= '0;
			brk_lvl_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL_ERR;
					end
				end
				ST_MUL_ERR: state_q <= ST_MUL_DAMP;
				ST_MUL_DAMP: state_q <= ST_VEL;
				ST_VEL: begin
					vel_q <= vel_nx;
					state_q <= ST_DECAY;
				end
				ST_DECAY: state_q <= ST_POS;
				ST_POS: begin
					pos_q <= pos_nx;
					state_q <= ST_NOISE;
				end
				ST_NOISE: begin
					off_q <= off_nx;
					state_q <= ST_STORE;
				end
				ST_STORE: begin
					thr_lvl_q <= thr_nx;
					brk_lvl_q <= brk_nx;
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (take) begin
						state_q <= start ? ST_MUL_ERR : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			tgt_q <= target_steer;
			thr_req_q <= throttle_in;
			brk_req_q <= brake_in;
			noise_q <= noise_sample;
		end
		prod_s1 <= mul_a * mul_b;
		if (state_q == ST_MUL_DAMP) begin
			acc_q <= prod_s1;
		end
		if (state_q == ST_DECAY) begin
			off_tmp_q <= off_tmp_nx;
		end
	end

	assign stat.idle = (state_q == ST_IDLE);
	assign stat.res_rdy = (state_q == ST_RESULT);

	assign ring_req.en = (state_q == ST_STORE);
	assign ring_req.lag = spsd_pkg::PtrW'(cfg.delay_samples);
	assign ring_req.wdata.steer = steer_nx;
	assign ring_req.wdata.throttle = thr_nx;
	assign ring_req.wdata.brake = brk_nx;

endmodule

[hw/rtl/steering_pedal_smoother_delay.sv]
// Steering and pedal smoother with reaction delay: config registers, output beat register.
// Depends on spsd_pkg, spsd_core and spsd_ring.
//
// Samples are taken one at a time: the core runs five products through a
// single 17x24 multiplier in sequence, then writes the new entry into the delay ring and
// reads the delayed entry in the same cycle. A result beat moves into the output register
// when the core is done and that register is free; the next sample may be accepted on
// the cycle the result is loaded, and is not held back by a stalled output until a
// second result is ready. The ring starts out reading zero (per-entry valid bits, no
// clearing pass). Write configuration only while idle; cfg_ready is always high and
// indexes past the register list are dropped.
module steering_pedal_smoother_delay (
	input logic clk,
	input logic arst_n,

	input logic in_valid,
	output logic in_stall,
	input logic signed [15:0] target_steer,
	input logic [14:0] throttle_in,
	input logic [14:0] brake_in,
	input logic signed [15:0] noise_sample,

	output logic out_valid,
	input logic out_stall,
	output logic signed [15:0] steer_out,
	output logic [14:0] throttle_out,
	output logic [14:0] brake_out,

	input logic cfg_valid,
	output logic cfg_ready,
	input logic [3:0] cfg_index,
	input logic [15:0] cfg_data
);

	spsd_pkg::cfg_t cfg_q;
	spsd_pkg::core_stat_t stat;
	spsd_pkg::ring_req_t ring_req;
	spsd_pkg::ring_entry_t ring_rdata;
	spsd_pkg::ring_entry_t out_q;
	logic out_valid_q;
	logic take;
	logic start;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spring_gain <= spsd_pkg::SpringGainRst;
			cfg_q.damping_gain <= spsd_pkg::DampingGainRst;
			cfg_q.time_step <= spsd_pkg::TimeStepRst;
			cfg_q.noise_decay <= spsd_pkg::NoiseDecayRst;
			cfg_q.noise_gain <= spsd_pkg::NoiseGainRst;
			cfg_q.throttle_step <= spsd_pkg::ThrottleStepRst;
			cfg_q.brake_step <= spsd_pkg::BrakeStepRst;
			cfg_q.delay_samples <= spsd_pkg::DelaySamplesRst;
		end else if (cfg_valid && cfg_ready) begin
			case (spsd_pkg::reg_idx_t'(cfg_index))
				spsd_pkg::RegSpringGain: cfg_q.spring_gain <= cfg_data;
				spsd_pkg::RegDampingGain: cfg_q.damping_gain <= cfg_data;
				spsd_pkg::RegTimeStep: cfg_q.time_step <= cfg_data;
				spsd_pkg::RegNoiseDecay: cfg_q.noise_decay <= cfg_data;
				spsd_pkg::RegNoiseGain: cfg_q.noise_gain <= cfg_data;
				spsd_pkg::RegThrottleStep: cfg_q.throttle_step <= cfg_data;
				spsd_pkg::RegBrakeStep: cfg_q.brake_step <= cfg_data;
				spsd_pkg::RegDelaySamples: cfg_q.delay_samples <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// result moves into the output register once that register is free
	assign take = stat.res_rdy && (!out_valid_q || !out_stall);
	assign in_stall = !(stat.idle || take);
	assign start = in_valid && !in_stall;

	spsd_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.start(start),
		.target_steer(target_steer),
		.throttle_in(throttle_in),
		.brake_in(brake_in),
		.noise_sample(noise_sample),
		.take(take),
		.stat(stat),
		.ring_req(ring_req)
	);

	spsd_ring u_ring (
		.clk(clk),
		.arst_n(arst_n),
		.req(ring_req),
		.rdata(ring_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= ring_rdata;
		end
	end

	assign out_valid = out_valid_q;
	assign steer_out = out_q.steer;
	assign throttle_out = out_q.throttle;
	assign brake_out = out_q.brake;

endmodule

[hw/rtl/spsd_checker.sv]
// Port-level checks for steering_pedal_smoother_delay, attached by bind.
// Depends on spsd_pkg for the steering limit.
module spsd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic signed [15:0] steer_out,
	input logic [14:0] throttle_out,
	input logic [14:0] brake_out
);

	// a result beat is held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(steer_out) && $stable(throttle_out)
			&& $stable(brake_out))
		else $error("stalled result beat changed");

	// the sequencer holds off a new sample while the previous one is in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall
			##1 in_stall ##1 in_stall ##1 in_stall)
		else $error("sample accepted while the previous one is in flight");

	a_steer_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (steer_out <= 16'(spsd_pkg::SteerLimit))
			&& (steer_out >= -16'(spsd_pkg::SteerLimit)))
		else $error("steering result beyond full scale");

endmodule

bind steering_pedal_smoother_delay spsd_checker u_spsd_checker (.*);

[dv/tb_top.sv]
// Self-checking bench for steering_pedal_smoother_delay: column, noise, pedal slew and lag ring.
// Uses spsd_pkg for register indexes, reset values, limits and the ring entry type.
// Test tasks run in turn from one initial block; one process scores every output beat.
module tb_top;
	import spsd_pkg::*;

	localparam int NumRegs = 8;
	localparam int SettleCycles = 16;
	localparam int PhaseItems = 43;

	typedef struct {
		logic signed [15:0] target;
		logic [14:0] throttle;
		logic [14:0] brake;
		logic signed [15:0] noise;
	} steer_sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] target_steer = '0;
	logic [14:0] throttle_in = '0;
	logic [14:0] brake_in = '0;
	logic signed [15:0] noise_sample = '0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] steer_out;
	logic [14:0] throttle_out;
	logic [14:0] brake_out;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [3:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	steering_pedal_smoother_delay DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.target_steer(target_steer),
		.throttle_in(throttle_in),
		.brake_in(brake_in),
		.noise_sample(noise_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.steer_out(steer_out),
		.throttle_out(throttle_out),
		.brake_out(brake_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the block: settings, column, noise, pedals and lag ring
	cfg_t shadow;
	logic signed [23:0] col_pos;
	logic signed [23:0] col_vel;
	logic signed [15:0] noise_off;
	logic [14:0] thr_lvl;
	logic [14:0] brk_lvl;
	ring_entry_t lag_ring [DelayDepth];
	logic [PtrW-1:0] wr_ptr;

	ring_entry_t delayed_q [$];

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;
	int mismatches = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int reg_writes = 0;
	int setups = 0;

	function automatic longint round_sh(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic [14:0] slew(logic [14:0] lvl, logic [14:0] req, logic [15:0] step);
		longint lim;
		longint d;
		lim = (longint'(step) + 2) >> 2;
		d = clip(longint'(req) - longint'(lvl), -lim, lim);
		return 15'(longint'(lvl) + d);
	endfunction

	// Advances the mirror by one sample and returns the entry read back from the ring
	function automatic ring_entry_t smooth_and_delay(steer_sample_t s);
		longint pos;
		longint vel;
		longint off;
		longint err;
		longint dv;
		longint steer;
		ring_entry_t fresh;
		logic [PtrW-1:0] rd;
		pos = col_pos;
		vel = col_vel;
		off = noise_off;
		err = longint'(s.target) * 64 - pos;
		dv = round_sh(longint'(shadow.spring_gain) * err - longint'(shadow.damping_gain) * vel, 16);
		vel = clip(vel + dv, VelMin, VelMax);
		pos = clip(pos + round_sh(vel * longint'(shadow.time_step), 16), -PosLimit, PosLimit);
		off = off - round_sh(longint'(shadow.noise_decay) * off, 16);
		off = off + round_sh(longint'(shadow.noise_gain) * longint'(s.noise), 21);
		off = clip(off, -NoiseLimit, NoiseLimit);
		steer = clip(round_sh(pos + off * 32, 6), -SteerLimit, SteerLimit);
		col_pos = pos[23:0];
		col_vel = vel[23:0];
		noise_off = off[15:0];
		thr_lvl = slew(thr_lvl, s.throttle, shadow.throttle_step);
		brk_lvl = slew(brk_lvl, s.brake, shadow.brake_step);
		fresh.steer = steer[15:0];
		fresh.throttle = thr_lvl;
		fresh.brake = brk_lvl;
		lag_ring[wr_ptr] = fresh;
		wr_ptr = wr_ptr + 1'b1;
		// lag of zero lands on the oldest entry, a full ring back
		rd = wr_ptr - shadow.delay_samples[PtrW-1:0];
		return lag_ring[rd];
	endfunction

	function automatic steer_sample_t sample_of(int t, int thr, int brk, int n);
		steer_sample_t s;
		s.target = 16'(t);
		s.throttle = 15'(thr);
		s.brake = 15'(brk);
		s.noise = 16'(n);
		return s;
	endfunction

	// Mostly in-range values with held stretches so the column can settle
	function automatic steer_sample_t random_sample(steer_sample_t last);
		steer_sample_t s;
		s = last;
		case ($urandom_range(9))
			0: s.target = 16'($urandom);
			1: s.target = $urandom_range(1) ? 16'(SteerLimit) : 16'(-SteerLimit);
			2, 3, 4, 5: ;
			default: s.target = 16'($urandom_range(2 * SteerLimit) - SteerLimit);
		endcase
		case ($urandom_range(7))
			0: s.throttle = 15'($urandom);
			1: s.throttle = '0;
			2: s.throttle = 15'(SteerLimit);
			3, 4: ;
			default: s.throttle = 15'($urandom_range(SteerLimit));
		endcase
		case ($urandom_range(7))
			0: s.brake = 15'($urandom);
			1: s.brake = '0;
			2: s.brake = 15'(SteerLimit);
			3, 4: ;
			default: s.brake = 15'($urandom_range(SteerLimit));
		endcase
		if ($urandom_range(2) == 0)
			s.noise = 16'($urandom);
		else
			s.noise = 16'($urandom_range(8192) - 4096);
		return s;
	endfunction

	function automatic logic [15:0] tune(int typical);
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(2 * typical + 1));
		endcase
	endfunction

	function automatic logic [15:0] pick_lag();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'd31;
			2: return {11'($urandom), 5'($urandom)};
			default: return 16'($urandom_range(12, 1));
		endcase
	endfunction

	task automatic flag(string what, logic signed [31:0] want, logic signed [31:0] got);
		mismatches++;
		$display("%0t: %s expected %0d got %0d", $time, what, want, got);
	endtask

	// Leaves valid high after the beat so the next sample can follow back to back
	task automatic offer_sample(steer_sample_t s);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		target_steer <= s.target;
		throttle_in <= s.throttle;
		brake_in <= s.brake;
		noise_sample <= s.noise;
		do
			@(posedge clk);
		while (in_stall);
		delayed_q.push_back(smooth_and_delay(s));
		samples_sent++;
	endtask

	task automatic write_reg(logic [3:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			RegSpringGain: shadow.spring_gain = val;
			RegDampingGain: shadow.damping_gain = val;
			RegTimeStep: shadow.time_step = val;
			RegNoiseDecay: shadow.noise_decay = val;
			RegNoiseGain: shadow.noise_gain = val;
			RegThrottleStep: shadow.throttle_step = val;
			RegBrakeStep: shadow.brake_step = val;
			RegDelaySamples: shadow.delay_samples = val[4:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Registers change only with the block idle: every beat out, then some slack
	task automatic drain();
		int guard;
		guard = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (delayed_q.size() != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic random_setup();
		write_reg(RegSpringGain, tune(SpringGainRst));
		write_reg(RegDampingGain, tune(DampingGainRst));
		write_reg(RegTimeStep, tune(TimeStepRst));
		write_reg(RegNoiseDecay, tune(NoiseDecayRst));
		write_reg(RegNoiseGain, tune(4096));
		write_reg(RegThrottleStep, tune(ThrottleStepRst));
		write_reg(RegBrakeStep, tune(BrakeStepRst));
		write_reg(RegDelaySamples, pick_lag());
		if ($urandom_range(3) == 0)
			write_reg(4'($urandom_range(15, NumRegs)), 16'($urandom));
		setups++;
	endtask

	// Reset settings; the first results come from ring slots not yet written
	task automatic test_reset_state();
		offer_sample(sample_of(SteerLimit, SteerLimit, 0, 0));
		offer_sample(sample_of(-SteerLimit, 0, SteerLimit, -32768));
		offer_sample(sample_of(32767, 32767, 32767, 32767));
		offer_sample(sample_of(-32768, 0, 0, 0));
		offer_sample(sample_of(0, SteerLimit, 32767, 1000));
		offer_sample(sample_of(SteerLimit, 0, 0, -1));
		offer_sample(sample_of(-1, 1, 1, 0));
		offer_sample(sample_of(0, 0, 0, 0));
		setups++;
	endtask

	// Gains at both ends; lag written with junk above its five bits
	task automatic test_register_extremes();
		drain();
		write_reg(RegSpringGain, 16'hFFFF);
		write_reg(RegDampingGain, 16'h0000);
		write_reg(RegTimeStep, 16'hFFFF);
		write_reg(RegNoiseDecay, 16'h0000);
		write_reg(RegNoiseGain, 16'hFFFF);
		write_reg(RegThrottleStep, 16'hFFFF);
		write_reg(RegBrakeStep, 16'h0000);
		write_reg(RegDelaySamples, 16'hFFE1);
		write_reg(4'(NumRegs), 16'h1234);
		write_reg(4'hF, 16'hFFFF);
		offer_sample(sample_of(32767, 32767, 32767, 32767));
		offer_sample(sample_of(-32768, 0, 0, -32768));
		offer_sample(sample_of(SteerLimit, SteerLimit, SteerLimit, 32767));
		offer_sample(sample_of(-SteerLimit, 0, 32767, -32768));
		offer_sample(sample_of(0, 12345, 0, 0));
		setups++;
		drain();
		write_reg(RegSpringGain, 16'h0000);
		write_reg(RegDampingGain, 16'hFFFF);
		write_reg(RegTimeStep, 16'h0000);
		write_reg(RegNoiseDecay, 16'hFFFF);
		write_reg(RegNoiseGain, 16'h8000);
		write_reg(RegThrottleStep, 16'h0000);
		write_reg(RegBrakeStep, 16'hFFFF);
		write_reg(RegDelaySamples, 16'd31);
		offer_sample(sample_of(SteerLimit, 32767, 0, 32767));
		offer_sample(sample_of(-SteerLimit, 0, 32767, -32768));
		offer_sample(sample_of(32767, 32767, 32767, 0));
		offer_sample(sample_of(-32768, 0, 0, 32767));
		offer_sample(sample_of(0, 0, SteerLimit, -32768));
		setups++;
	endtask

	// Lag of zero reads back a whole ring late
	task automatic test_zero_delay();
		drain();
		write_reg(RegSpringGain, SpringGainRst);
		write_reg(RegTimeStep, TimeStepRst);
		write_reg(RegDelaySamples, 16'd0);
		write_reg(4'(NumRegs + 3), 16'h0005);
		offer_sample(sample_of(8000, 4000, 2000, 500));
		offer_sample(sample_of(-8000, 0, 16384, -500));
		offer_sample(sample_of(100, 16384, 0, 0));
		offer_sample(sample_of(-100, 0, 0, 32767));
		setups++;
	endtask

	task automatic test_random_phases();
		int idle_mix [4] = '{0, 77, 0, 13};
		int stall_mix [4] = '{0, 0, 77, 13};
		steer_sample_t s;
		s = sample_of(0, 0, 0, 0);
		for (int p = 0; p < 8; p++) begin
			drain();
			random_setup();
			idle_pct = idle_mix[p % 4];
			stall_pct = stall_mix[p % 4];
			repeat (PhaseItems) begin
				s = random_sample(s);
				offer_sample(s);
			end
		end
	endtask

	// Output held off for a long stretch while samples keep coming
	task automatic test_backpressure();
		steer_sample_t s;
		s = sample_of(0, 0, 0, 0);
		drain();
		random_setup();
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 120;
		repeat (40) begin
			s = random_sample(s);
			offer_sample(s);
		end
		stall_pct = 13;
	endtask

	always @(negedge clk) begin
		if (hold_left == 0 && hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		ring_entry_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (delayed_q.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with none pending, expected none got %0d/%0d/%0d",
					$time, steer_out, throttle_out, brake_out);
			end else begin
				want = delayed_q.pop_front();
				if (steer_out !== want.steer)
					flag("steer_out", want.steer, steer_out);
				if (throttle_out !== want.throttle)
					flag("throttle_out", want.throttle, throttle_out);
				if (brake_out !== want.brake)
					flag("brake_out", want.brake, brake_out);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("steering_pedal_smoother_delay regression: fail");
		$finish;
	end

	initial begin
		shadow = '{SpringGainRst, DampingGainRst, TimeStepRst, NoiseDecayRst, NoiseGainRst,
			ThrottleStepRst, BrakeStepRst, DelaySamplesRst};
		col_pos = '0;
		col_vel = '0;
		noise_off = '0;
		thr_lvl = '0;
		brk_lvl = '0;
		wr_ptr = '0;
		foreach (lag_ring[i])
			lag_ring[i] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_register_extremes();
		test_zero_delay();
		test_random_phases();
		test_backpressure();
		drain();

		if (delayed_q.size() != 0) begin
			mismatches++;
			$display("%0t: %0d result beats never arrived", $time, delayed_q.size());
		end
		$display("Covered %0d samples across %0d register setups (gain extremes, lags 0 to 31,",
			samples_sent, setups);
		$display("out-of-range inputs, long output hold-off); %0d beats scored, %0d reg writes",
			results_seen, reg_writes);
		if (mismatches == 0)
			$display("steering_pedal_smoother_delay regression: pass");
		else
			$display("steering_pedal_smoother_delay regression: fail");
		$finish;
	end

endmodule
